FILE: hw/rtl/rgnrf_pkg.sv
package rgnrf_pkg;

  localparam int MAX_GATES   = 1024;
  localparam int MAX_PENDING = 31;
  localparam int FIELD_BYTES = 8;

  localparam int POS_W  = 10;
  localparam int AG_W   = 11;
  localparam int DATA_W = 64;
  localparam int THR_W  = 8;
  localparam int RUN_W  = 6;
  localparam int RUN_MAX = 63;
  localparam int RUN_CAP = (MAX_PENDING + 1 < 32) ? MAX_PENDING + 1 : 32;

  localparam int PCNT_W = $clog2(MAX_PENDING + 1);
  localparam int PIDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DBZ_SEL     = 2'd2;

  localparam logic CMD_TABLE = 1'b0;
  localparam logic CMD_GATE  = 1'b1;

  localparam logic OP_HOLD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [POS_W-1:0]  table_address;
    logic [THR_W-1:0]  threshold_value;
    logic [DATA_W-1:0] gate_bytes;
    logic [AG_W-1:0]   active_gates;
    logic              last_gate;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  gate_position;
    logic              kept;
    logic [DATA_W-1:0] gate_data;
    logic              end_of_beam;
  } out_word_t;

  typedef struct packed {
    logic              op;
    logic              flush_kept;
    logic              cur_kept;
    logic              last;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] data;
  } cmd_word_t;

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] r;
    if (p == POS_W'(MAX_GATES - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/radar_gate_noise_run_filter_unit.sv
// A gate whose outcome is known passes the front stage register, the command queue and the result
// register before it shows on the result side; threshold table writes produce no word.
// Throughput: one gate per cycle while nothing is held and result words are popped; held gates
// are stored by the back end and put out in order ahead of the gate that releases them.
// Reset restores the configuration defaults and clears counters and queues; the threshold table
// and the held-gate store are undefined until written and get no clearing pass.
module radar_gate_noise_run_filter_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  rgnrf_pkg::in_word_t                 in_data,
  output logic                                empty,
  input  logic                                pop,
  output rgnrf_pkg::out_word_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgnrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgnrf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                  fq_valid;
  logic                  fq_ready;
  rgnrf_pkg::cmd_word_t  fq_word;
  logic                  bq_valid;
  logic                  bq_ready;
  rgnrf_pkg::cmd_word_t  bq_word;

  rgnrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_word    (fq_word)
  );

  rgnrf_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_word  (fq_word),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_word  (bq_word)
  );

  rgnrf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (bq_valid),
    .q_ready  (bq_ready),
    .q_word   (bq_word),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

FILE: hw/rtl/rgnrf_front.sv
module rgnrf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  rgnrf_pkg::in_word_t                 in_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgnrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgnrf_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                q_valid,
  input  logic                                q_ready,
  output rgnrf_pkg::cmd_word_t                q_word
);

  logic                            check_noise;
  logic [rgnrf_pkg::RUN_W-1:0]     min_valid_run;
  logic [2:0]                      dbz_byte_select;

  logic [rgnrf_pkg::THR_W-1:0]     threshold_table [rgnrf_pkg::MAX_GATES];
  logic [rgnrf_pkg::POS_W-1:0]     gate_counter;
  logic [rgnrf_pkg::RUN_W-1:0]     streak_len;
  logic [rgnrf_pkg::PCNT_W-1:0]    pending_count;

  logic                            s1_valid;
  logic [rgnrf_pkg::POS_W-1:0]     s1_pos;
  logic [rgnrf_pkg::DATA_W-1:0]    s1_data;
  logic [rgnrf_pkg::AG_W-1:0]      s1_active_gates;
  logic                            s1_last;
  logic [rgnrf_pkg::THR_W-1:0]     s1_thr;

  logic                            accept;
  logic                            gate_accept;
  logic                            s1_fire;
  logic [7:0]                      dbz;
  logic                            pass;
  logic                            active;
  logic [rgnrf_pkg::RUN_W-1:0]     eff;
  logic [rgnrf_pkg::RUN_W-1:0]     run_next;
  logic                            hold;

  assign cfg_ready   = 1'b1;
  assign full        = s1_valid && !q_ready;
  assign accept      = push && !full;
  assign gate_accept = accept && (in_data.cmd == rgnrf_pkg::CMD_GATE);
  assign s1_fire     = s1_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_noise     <= 1'b1;
      min_valid_run   <= rgnrf_pkg::RUN_W'(1);
      dbz_byte_select <= 3'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rgnrf_pkg::CFG_CHECK_NOISE: check_noise     <= cfg_data[0];
        rgnrf_pkg::CFG_MIN_RUN:     min_valid_run   <= cfg_data[rgnrf_pkg::RUN_W-1:0];
        rgnrf_pkg::CFG_DBZ_SEL:     dbz_byte_select <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_data.cmd == rgnrf_pkg::CMD_TABLE)) begin
      threshold_table[in_data.table_address] <= in_data.threshold_value;
    end
    if (gate_accept) begin
      s1_thr <= threshold_table[gate_counter];
    end
  end

  always_ff @(posedge clk) begin
    if (gate_accept) begin
      s1_pos          <= gate_counter;
      s1_data         <= in_data.gate_bytes;
      s1_active_gates <= in_data.active_gates;
      s1_last         <= in_data.last_gate;
    end
  end

  always_comb begin
    if (int'(dbz_byte_select) < rgnrf_pkg::FIELD_BYTES) begin
      dbz = s1_data[{dbz_byte_select, 3'b000} +: 8];
    end else begin
      dbz = 8'd0;
    end
    pass   = dbz > s1_thr;
    active = {1'b0, s1_pos} < s1_active_gates;
    if (min_valid_run > rgnrf_pkg::RUN_W'(rgnrf_pkg::RUN_CAP)) begin
      eff = rgnrf_pkg::RUN_W'(rgnrf_pkg::RUN_CAP);
    end else begin
      eff = min_valid_run;
    end
    if (streak_len < rgnrf_pkg::RUN_W'(rgnrf_pkg::RUN_MAX)) begin
      run_next = streak_len + 1'b1;
    end else begin
      run_next = streak_len;
    end
    hold = check_noise && active && pass && (run_next < eff) &&
           (pending_count < rgnrf_pkg::PCNT_W'(rgnrf_pkg::MAX_PENDING));
  end

  assign q_valid             = s1_valid;
  assign q_word.op           = (hold && !s1_last) ? rgnrf_pkg::OP_HOLD : rgnrf_pkg::OP_EMIT;
  assign q_word.flush_kept   = !check_noise || !active || pass;
  assign q_word.cur_kept     = !check_noise || pass;
  assign q_word.last         = s1_last;
  assign q_word.pos          = s1_pos;
  assign q_word.data         = s1_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      gate_counter  <= '0;
      streak_len    <= '0;
      pending_count <= '0;
    end else begin
      if (gate_accept) begin
        s1_valid <= 1'b1;
        if (in_data.last_gate) begin
          gate_counter <= '0;
        end else begin
          gate_counter <= rgnrf_pkg::next_pos(gate_counter);
        end
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        priority if (s1_last || !check_noise || !active || !pass) begin
          streak_len    <= '0;
          pending_count <= '0;
        end else if (hold) begin
          streak_len    <= run_next;
          pending_count <= pending_count + 1'b1;
        end else begin
          streak_len    <= run_next;
          pending_count <= '0;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/rgnrf_cmd_queue.sv
module rgnrf_cmd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  rgnrf_pkg::cmd_word_t  wr_word,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output rgnrf_pkg::cmd_word_t  rd_word
);

  rgnrf_pkg::cmd_word_t             slots [rgnrf_pkg::CQ_DEPTH];
  logic [rgnrf_pkg::CQ_PTR_W-1:0]   wr_ptr;
  logic [rgnrf_pkg::CQ_PTR_W-1:0]   rd_ptr;
  logic [rgnrf_pkg::CQ_PTR_W:0]     count;
  logic                             do_wr;
  logic                             do_rd;

  assign wr_ready = count != (rgnrf_pkg::CQ_PTR_W + 1)'(rgnrf_pkg::CQ_DEPTH);
  assign rd_valid = count != '0;
  assign rd_word  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/rgnrf_back.sv
module rgnrf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  rgnrf_pkg::cmd_word_t  q_word,
  output logic                  empty,
  input  logic                  pop,
  output rgnrf_pkg::out_word_t  out_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_CUR   = 2'd2;

  logic [1:0]                     state;
  logic [1:0]                     state_next;
  logic [rgnrf_pkg::DATA_W-1:0]   pending_gates [rgnrf_pkg::MAX_PENDING];
  logic [rgnrf_pkg::PCNT_W-1:0]   pending_count;
  logic [rgnrf_pkg::POS_W-1:0]    start_pos;
  logic [rgnrf_pkg::PIDX_W-1:0]   idx;
  logic [rgnrf_pkg::POS_W-1:0]    fpos;
  rgnrf_pkg::cmd_word_t           cur;
  logic [rgnrf_pkg::DATA_W-1:0]   rd_data;
  logic                           out_valid;

  logic                           slot_free;
  logic                           load;
  rgnrf_pkg::out_word_t           load_word;
  logic                           hold_fire;
  logic                           flush_step;
  logic                           flush_done;
  logic [rgnrf_pkg::PCNT_W-1:0]   rd_addr;

  assign empty      = !out_valid;
  assign slot_free  = !out_valid || pop;
  assign hold_fire  = (state == ST_IDLE) && q_valid && (q_word.op == rgnrf_pkg::OP_HOLD);
  assign flush_step = (state == ST_FLUSH) && slot_free;
  assign flush_done = ({1'b0, idx} + 1'b1) == {1'b0, pending_count};

  always_comb begin
    q_ready    = 1'b0;
    load       = 1'b0;
    load_word  = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_word.op == rgnrf_pkg::OP_HOLD) begin
            q_ready = 1'b1;
          end else if (pending_count == '0) begin
            q_ready = slot_free;
            load    = slot_free;
            load_word.gate_position = q_word.pos;
            load_word.kept          = q_word.cur_kept;
            load_word.gate_data     = q_word.data;
            load_word.end_of_beam   = q_word.last;
          end else begin
            q_ready    = 1'b1;
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          load = 1'b1;
          load_word.gate_position = fpos;
          load_word.kept          = cur.flush_kept;
          load_word.gate_data     = rd_data;
          load_word.end_of_beam   = 1'b0;
          if (flush_done) begin
            state_next = ST_CUR;
          end
        end
      end
      ST_CUR: begin
        if (slot_free) begin
          load = 1'b1;
          load_word.gate_position = cur.pos;
          load_word.kept          = cur.cur_kept;
          load_word.gate_data     = cur.data;
          load_word.end_of_beam   = cur.last;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (state != ST_FLUSH) begin
      rd_addr = '0;
    end else if (flush_step) begin
      rd_addr = rgnrf_pkg::PCNT_W'(idx) + 1'b1;
    end else begin
      rd_addr = rgnrf_pkg::PCNT_W'(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (hold_fire) begin
      pending_gates[pending_count[rgnrf_pkg::PIDX_W-1:0]] <= q_word.data;
    end
    if (rd_addr < rgnrf_pkg::PCNT_W'(rgnrf_pkg::MAX_PENDING)) begin
      rd_data <= pending_gates[rd_addr[rgnrf_pkg::PIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_word;
    end
    if (hold_fire && (pending_count == '0)) begin
      start_pos <= q_word.pos;
    end
    if ((state == ST_IDLE) && q_ready && (q_word.op == rgnrf_pkg::OP_EMIT)) begin
      cur  <= q_word;
      fpos <= start_pos;
      idx  <= '0;
    end else if (flush_step) begin
      fpos <= rgnrf_pkg::next_pos(fpos);
      idx  <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pending_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (hold_fire) begin
        pending_count <= pending_count + 1'b1;
      end else if ((state == ST_CUR) && slot_free) begin
        pending_count <= '0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/rgnrf_checker.sv
module rgnrf_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  rgnrf_pkg::in_word_t   in_data,
  input  logic                  empty,
  input  logic                  pop,
  input  rgnrf_pkg::out_word_t  out_data
);

  logic [rgnrf_pkg::POS_W-1:0]  exp_pos;
  logic [7:0]                   outstanding;
  logic                         gate_in;
  logic                         word_out;

  assign gate_in  = push && !full && (in_data.cmd == rgnrf_pkg::CMD_GATE);
  assign word_out = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_pos     <= '0;
      outstanding <= '0;
    end else begin
      if (word_out) begin
        if (out_data.end_of_beam) begin
          exp_pos <= '0;
        end else begin
          exp_pos <= rgnrf_pkg::next_pos(out_data.gate_position);
        end
      end
      if (gate_in && !word_out) begin
        outstanding <= outstanding + 1'b1;
      end else if (word_out && !gate_in) begin
        outstanding <= outstanding - 1'b1;
      end
    end
  end

  // Every gate yields one word, in gate order, so positions run on without gaps.
  a_pos_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_data.gate_position == exp_pos)
    else $error("result gate position out of sequence");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !empty |-> outstanding != 8'd0)
    else $error("result word without an accepted gate");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result side not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result word changed");

endmodule

bind radar_gate_noise_run_filter_unit rgnrf_checker u_rgnrf_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .in_data  (in_data),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

FILE: dv/testbench.sv
module testbench;
  import rgnrf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int LOADED_GATES = 72;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_word_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  radar_gate_noise_run_filter_unit DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Filter state as the block should hold it.
  logic [THR_W-1:0] thr_mem [MAX_GATES];
  logic [DATA_W-1:0] held_words [$];
  int run_count = 0;
  int beam_pos = 0;
  logic chk_noise = 1'b1;
  logic [5:0] min_run = 6'd1;
  logic [2:0] dbz_sel = 3'd0;

  out_word_t expected_words [$];
  int mismatches = 0;
  int words_sent = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int hold_request = 0;

  function automatic void add_expected(int pos, logic kept, logic [DATA_W-1:0] data);
    out_word_t w;
    w.gate_position = POS_W'(pos);
    w.kept = kept;
    w.gate_data = data;
    w.end_of_beam = 1'b0;
    expected_words.push_back(w);
  endfunction

  // The held gates end just before after_pos, so positions are counted back from it.
  function automatic void release_held(int after_pos, logic kept);
    int start;
    start = (after_pos + MAX_GATES - held_words.size()) % MAX_GATES;
    foreach (held_words[i]) add_expected((start + i) % MAX_GATES, kept, held_words[i]);
    held_words.delete();
  endfunction

  function automatic void predict_filter(in_word_t w);
    int pos;
    int eff;
    logic [THR_W-1:0] dbz;
    bit pass;
    bit in_range;
    if (w.cmd == CMD_TABLE) begin
      thr_mem[w.table_address] = w.threshold_value;
      return;
    end
    pos = beam_pos;
    dbz = w.gate_bytes[8*dbz_sel +: 8];
    pass = dbz > thr_mem[pos];
    in_range = pos < int'(w.active_gates);
    eff = (int'(min_run) > RUN_CAP) ? RUN_CAP : int'(min_run);
    if (!chk_noise || !in_range) begin
      release_held(pos, 1'b1);
      run_count = 0;
      add_expected(pos, chk_noise ? pass : 1'b1, w.gate_bytes);
    end else if (pass) begin
      if (run_count < RUN_MAX) run_count++;
      if (run_count >= eff || held_words.size() >= MAX_PENDING) begin
        release_held(pos, 1'b1);
        add_expected(pos, 1'b1, w.gate_bytes);
      end else begin
        held_words.push_back(w.gate_bytes);
      end
    end else begin
      release_held(pos, 1'b0);
      run_count = 0;
      add_expected(pos, 1'b0, w.gate_bytes);
    end
    if (w.last_gate) begin
      release_held((pos + 1) % MAX_GATES, 1'b1);
      expected_words[expected_words.size() - 1].end_of_beam = 1'b1;
      beam_pos = 0;
      run_count = 0;
    end else begin
      beam_pos = (pos + 1) % MAX_GATES;
    end
  endfunction

  function automatic in_word_t make_table(int unsigned addr, int unsigned val);
    in_word_t w;
    w.cmd = CMD_TABLE;
    w.table_address = POS_W'(addr);
    w.threshold_value = THR_W'(val);
    w.gate_bytes = {$urandom, $urandom};
    w.active_gates = AG_W'($urandom);
    w.last_gate = 1'($urandom);
    return w;
  endfunction

  function automatic in_word_t make_gate(bit want_pass, int unsigned active, bit last);
    in_word_t w;
    logic [THR_W-1:0] thr;
    w.cmd = CMD_GATE;
    w.table_address = POS_W'($urandom);
    w.threshold_value = THR_W'($urandom);
    w.gate_bytes = {$urandom, $urandom};
    w.active_gates = AG_W'(active);
    w.last_gate = last;
    thr = thr_mem[beam_pos];
    if (want_pass && thr != 8'hFF) begin
      w.gate_bytes[8*dbz_sel +: 8] = 8'($urandom_range(255, int'(thr) + 1));
    end else if (!want_pass) begin
      w.gate_bytes[8*dbz_sel +: 8] = 8'($urandom_range(int'(thr), 0));
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(9, 0);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (full);
    predict_filter(w);
    words_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CHECK_NOISE: chk_noise = val[0];
      CFG_MIN_RUN: min_run = val;
      CFG_DBZ_SEL: dbz_sel = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(logic chk, logic [5:0] run, logic [2:0] sel);
    write_cfg(CFG_CHECK_NOISE, CFG_DATA_W'(chk));
    write_cfg(CFG_MIN_RUN, run);
    write_cfg(CFG_DBZ_SEL, CFG_DATA_W'(sel));
  endtask

  // Runs of passing gates are sized around the minimum run so that both
  // outcomes are common, with some gates left to chance.
  task automatic send_beam(int unsigned len, int unsigned active);
    bit pass;
    bit want;
    int run_left;
    pass = 1'b0;
    run_left = 0;
    for (int g = 0; g < len; g++) begin
      if (run_left == 0) begin
        pass = !pass;
        if (!pass) begin
          run_left = $urandom_range(3, 1);
        end else begin
          case ($urandom_range(3, 0))
            0: run_left = (min_run > 1) ? min_run - 1 : 1;
            1: run_left = (min_run > 0) ? min_run : 1;
            2: run_left = min_run + 1;
            default: run_left = $urandom_range(40, 1);
          endcase
        end
      end
      if ($urandom_range(9, 0) == 0) send_word(make_table($urandom, $urandom));
      want = ($urandom_range(9, 0) == 0) ? 1'($urandom) : pass;
      send_word(make_gate(want, active, g == len - 1));
      run_left--;
    end
  endtask

  // Every beam stays within the gate positions loaded here.
  task automatic load_threshold_table();
    tx_burst = 1'b1;
    for (int a = 0; a < LOADED_GATES; a++) begin
      if (a == LOADED_GATES / 2) tx_burst = 1'b0;
      send_word(make_table(a, $urandom_range(254, 0)));
    end
  endtask

  task automatic test_gating_extremes();
    in_word_t w;
    send_word(make_table(0, 0));
    send_word(make_table(1, 255));
    send_word(make_table(2, 8'h80));
    send_word(make_table(3, 8'h7F));
    w = make_gate(1'b1, MAX_GATES, 1'b0);
    w.gate_bytes = '1;
    send_word(w);
    w = make_gate(1'b0, MAX_GATES, 1'b0);
    w.gate_bytes = '1;
    send_word(w);
    w = make_gate(1'b0, MAX_GATES, 1'b0);
    w.gate_bytes = '0;
    send_word(w);
    w = make_gate(1'b1, MAX_GATES, 1'b1);
    w.gate_bytes = 64'h80;
    send_word(w);
    send_word(make_table(1, $urandom_range(254, 0)));
  endtask

  task automatic test_short_runs();
    bit pattern [7] = '{1, 1, 0, 1, 1, 0, 1};
    set_filter(1'b1, 6'd3, 3'd7);
    for (int g = 0; g < 7; g++) send_word(make_gate(pattern[g], 5, g == 6));
    send_word(make_gate(1'b1, MAX_GATES, 1'b0));
    send_word(make_gate(1'b1, MAX_GATES, 1'b1));
  endtask

  task automatic test_midbeam_config();
    in_word_t w;
    set_filter(1'b1, 6'd4, 3'd0);
    send_word(make_gate(1'b1, MAX_GATES, 1'b0));
    send_word(make_gate(1'b1, MAX_GATES, 1'b0));
    write_cfg(CFG_CHECK_NOISE, CFG_DATA_W'(0));
    send_word(make_gate(1'b0, MAX_GATES, 1'b0));
    w = make_gate(1'b0, MAX_GATES, 1'b1);
    w.gate_bytes = '0;
    send_word(w);
    write_cfg(CFG_CHECK_NOISE, CFG_DATA_W'(1));
  endtask

  // A run long enough to reach the run counter's ceiling.
  task automatic test_long_beam();
    set_filter(1'b1, 6'd40, 3'($urandom));
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    for (int g = 0; g < 70; g++) begin
      send_word(make_gate((g < 66) || ($urandom_range(9, 0) != 0), 2047, g == 69));
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  task automatic test_random_beams();
    int start;
    int unsigned len;
    int unsigned active;
    write_cfg(CFG_SPARE, CFG_DATA_W'($urandom));
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_filter(1'b1, 6'd1, 3'd0);
        1: set_filter(1'b1, 6'd0, 3'd3);
        2: set_filter(1'b1, 6'd3, 3'd7);
        3: set_filter(1'b1, 6'd32, 3'd5);
        4: set_filter(1'b1, 6'd63, 3'd2);
        5: set_filter(1'b0, 6'd5, 3'd1);
        default: set_filter(1'($urandom), 6'($urandom), 3'($urandom));
      endcase
      tx_burst = ($urandom_range(3, 0) == 0);
      rx_burst = ($urandom_range(3, 0) == 0);
      if (p == 0) begin
        hold_request = 300;
        tx_burst = 1'b1;
        send_beam(16, MAX_GATES);
        tx_burst = 1'b0;
      end
      start = words_sent;
      while (words_sent - start < 6) begin
        len = ($urandom_range(7, 0) == 0) ? $urandom_range(36, 13) : $urandom_range(10, 1);
        case ($urandom_range(4, 0))
          0: active = len;
          1: active = $urandom_range(len, 0);
          2: active = 0;
          3: active = MAX_GATES;
          default: active = $urandom_range(2047, MAX_GATES + 1);
        endcase
        send_beam(len, active);
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(9, 0);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && pop && !empty) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: pos %0d kept %0b data %h eob %0b",
                   out_data.gate_position, out_data.kept, out_data.gate_data,
                   out_data.end_of_beam);
        end
      end else begin
        want = expected_words.pop_front();
        if (out_data.gate_position !== want.gate_position || out_data.kept !== want.kept ||
            out_data.gate_data !== want.gate_data ||
            out_data.end_of_beam !== want.end_of_beam) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected pos %0d kept %0b data %h eob %0b",
                     want.gate_position, want.kept, want.gate_data, want.end_of_beam);
            $display("          got      pos %0d kept %0b data %h eob %0b",
                     out_data.gate_position, out_data.kept, out_data.gate_data,
                     out_data.end_of_beam);
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("radar_gate_noise_run_filter_unit test failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    load_threshold_table();
    test_gating_extremes();
    test_short_runs();
    test_midbeam_config();
    test_long_beam();
    test_random_beams();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("radar_gate_noise_run_filter_unit test passed");
    end else begin
      $display("radar_gate_noise_run_filter_unit test failed");
    end
    $finish;
  end

endmodule
